>>> hw/rtl/lca_pkg.sv
// Shared types and constants for the linear classifier argmax unit.
// No dependencies; imported by every module of the block except lca_ram.
`default_nettype none

package lca_pkg;

    localparam int MAX_CLASSES  = 16;
    localparam int MAX_FEATURES = 256;

    localparam int CLS_W    = 4;
    localparam int POS_W    = 9;
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int SCORE_W  = 48;
    localparam int LABEL_W  = 5;
    localparam int CFG_W    = 9;

    localparam int ROW_LEN     = MAX_FEATURES + 1;
    localparam int STORE_DEPTH = MAX_CLASSES * ROW_LEN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam longint FLOOR_VALUE = -10000;
    localparam int     SCORE_FRAC  = 20;
    localparam logic signed [SCORE_W-1:0] SCORE_FLOOR =
        SCORE_W'(FLOOR_VALUE * (longint'(1) <<< SCORE_FRAC));
    localparam logic signed [LABEL_W-1:0] LABEL_NONE = -5'sd1;

    localparam logic signed [DATA_W-1:0] BIAS_SCALE = 16'sd256;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_FEATURE = 1'b1;

    localparam logic [0:0] CFG_FEATURE_COUNT = 1'b0;
    localparam logic [0:0] CFG_CLASS_COUNT   = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_BIAS  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } seq_state_t;

    typedef struct packed {
        logic             valid;
        logic [CLS_W-1:0] cls;
        logic             clear;
        logic             bias;
    } mac_tok_t;

endpackage

`default_nettype wire

>>> hw/rtl/lca_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lca_mac.sv
// Shared multiply-accumulate datapath: multiply, saturating add into the
// class accumulators, and the running argmax compare. Depends on lca_pkg.
`default_nettype none

module lca_mac
    import lca_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mac_tok_t                  tok_in,
    input  wire logic signed [DATA_W-1:0]  weight,
    input  wire logic signed [DATA_W-1:0]  feature,
    input  wire logic [CLS_W-1:0]          rd_idx,
    output logic signed [SCORE_W-1:0]      rd_score,
    output logic signed [SCORE_W-1:0]      best_score,
    output logic signed [LABEL_W-1:0]      best_label,
    output logic                           busy
);

    mac_tok_t                   p1_reg, p2_reg, p3_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SCORE_W-1:0]  sum_reg;
    logic signed [SCORE_W-1:0]  acc_reg [MAX_CLASSES];
    logic signed [SCORE_W-1:0]  best_reg;
    logic signed [LABEL_W-1:0]  label_reg;

    logic [CLS_W-1:0]           acc_idx;
    logic signed [SCORE_W-1:0]  acc_old;
    logic signed [SCORE_W:0]    sum_wide;
    logic signed [SCORE_W-1:0]  sum_sat;
    logic signed [DATA_W-1:0]   mul_b;
    logic                       first_bias;
    logic                       clear_all;
    logic signed [SCORE_W-1:0]  cmp_ref;

    always_comb
    begin
        acc_idx  = p2_reg.valid ? p2_reg.cls : rd_idx;
        rd_score = acc_reg[acc_idx];
        acc_old  = p2_reg.clear ? '0 : acc_reg[acc_idx];
        sum_wide = {acc_old[SCORE_W-1], acc_old}
                 + {{(SCORE_W + 1 - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (sum_wide[SCORE_W] != sum_wide[SCORE_W-1])
        begin
            sum_sat = sum_wide[SCORE_W] ? {1'b1, {(SCORE_W - 1){1'b0}}}
                                        : {1'b0, {(SCORE_W - 1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SCORE_W-1:0];
        end
        mul_b      = p1_reg.bias ? BIAS_SCALE : feature;
        first_bias = p3_reg.bias && (p3_reg.cls == '0);
        clear_all  = p2_reg.valid && p2_reg.clear && (p2_reg.cls == '0);
        cmp_ref    = first_bias ? SCORE_FLOOR : best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
        end
        else
        begin
            p1_reg <= tok_in;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= weight * mul_b;
        sum_reg  <= sum_sat;
        for (int i = 0; i < MAX_CLASSES; i++)
        begin
            if (p2_reg.valid && (acc_idx == CLS_W'(i)))
            begin
                acc_reg[i] <= sum_sat;
            end
            else if (clear_all)
            begin
                acc_reg[i] <= '0;
            end
        end
        if (p3_reg.valid && p3_reg.bias)
        begin
            if (sum_reg > cmp_ref)
            begin
                best_reg  <= sum_reg;
                label_reg <= $signed({1'b0, p3_reg.cls});
            end
            else if (first_bias)
            begin
                best_reg  <= SCORE_FLOOR;
                label_reg <= LABEL_NONE;
            end
        end
    end

    assign best_score = best_reg;
    assign best_label = label_reg;
    assign busy       = p1_reg.valid || p2_reg.valid || p3_reg.valid;

endmodule

`default_nettype wire

>>> hw/rtl/linear_classifier_argmax_unit.sv
// A load beat leaves in_ready high; a feature beat keeps in_ready low for one
// pass of the shared multiply-accumulate per class, over class_count classes.
// The final feature beat of a sample adds a bias pass per class and a
// pipeline drain, then emits one result per cycle while out_ready
// stays high. Reset clears control state and restores the register defaults;
// the weight store is not initialized.
`default_nettype none

module linear_classifier_argmax_unit
    import lca_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      write_enable,
    input  wire logic [0:0]                write_index,
    input  wire logic [CFG_W-1:0]          write_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      command,
    input  wire logic [CLS_W-1:0]          weight_class,
    input  wire logic [POS_W-1:0]          weight_position,
    input  wire logic signed [DATA_W-1:0]  weight_value,
    input  wire logic signed [DATA_W-1:0]  feature_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [CLS_W-1:0]               class_index,
    output logic signed [SCORE_W-1:0]      class_score,
    output logic                           last_of_run,
    output logic signed [LABEL_W-1:0]      best_label,
    output logic signed [SCORE_W-1:0]      best_score
);

    seq_state_t                 state_reg, state_next;
    logic [POS_W-1:0]           fc_reg;
    logic [CNT_W-1:0]           cc_reg;
    logic [POS_W-1:0]           ec_reg, ec_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [CLS_W-1:0]           cls_reg, cls_next;
    logic [CLS_W-1:0]           oc_reg, oc_next;
    logic                       clear_reg, clear_next;
    logic                       final_reg, final_next;
    logic signed [DATA_W-1:0]   feat_reg, feat_next;

    logic                       out_valid_reg;
    logic [CLS_W-1:0]           out_cls_reg;
    logic signed [SCORE_W-1:0]  out_score_reg;
    logic                       out_last_reg;
    logic signed [LABEL_W-1:0]  out_label_reg;
    logic signed [SCORE_W-1:0]  out_best_reg;

    logic [POS_W-1:0]           nf;
    logic [CNT_W-1:0]           nc;
    logic [POS_W-1:0]           ec_eff;
    logic                       accept;
    logic                       issue_last;
    logic                       emit_last;
    logic                       out_load;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic [POS_W-1:0]           rd_pos;
    logic [DATA_W-1:0]          rd_data;
    mac_tok_t                   tok;
    logic signed [SCORE_W-1:0]  acc_score;
    logic signed [SCORE_W-1:0]  mac_best_score;
    logic signed [LABEL_W-1:0]  mac_best_label;
    logic                       mac_busy;

    always_comb
    begin
        if (fc_reg == '0)
        begin
            nf = POS_W'(1);
        end
        else if (fc_reg > POS_W'(MAX_FEATURES))
        begin
            nf = POS_W'(MAX_FEATURES);
        end
        else
        begin
            nf = fc_reg;
        end
        if (cc_reg == '0)
        begin
            nc = CNT_W'(1);
        end
        else if (cc_reg > CNT_W'(MAX_CLASSES))
        begin
            nc = CNT_W'(MAX_CLASSES);
        end
        else
        begin
            nc = cc_reg;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign ec_eff     = (ec_reg >= nf) ? '0 : ec_reg;
    assign issue_last = ({1'b0, cls_reg} == CNT_W'(nc - CNT_W'(1)));
    assign emit_last  = ({1'b0, oc_reg} == CNT_W'(nc - CNT_W'(1)));
    assign out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= POS_W'(MAX_FEATURES);
            cc_reg <= CNT_W'(2);
        end
        else if (write_enable)
        begin
            unique case (write_index)
                CFG_FEATURE_COUNT: fc_reg <= write_data;
                CFG_CLASS_COUNT:   cc_reg <= write_data[CNT_W-1:0];
                default:           fc_reg <= fc_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ec_next    = ec_reg;
        pos_next   = pos_reg;
        cls_next   = cls_reg;
        oc_next    = oc_reg;
        clear_next = clear_reg;
        final_next = final_reg;
        feat_next  = feat_reg;
        tok        = '0;
        rd_pos     = pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_FEATURE))
                begin
                    pos_next   = ec_eff;
                    clear_next = (ec_eff == '0);
                    final_next = (ec_eff == POS_W'(nf - POS_W'(1)));
                    ec_next    = (ec_eff == POS_W'(nf - POS_W'(1)))
                               ? '0 : POS_W'(ec_eff + POS_W'(1));
                    feat_next  = feature_value;
                    cls_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                tok = '{valid: 1'b1, cls: cls_reg, clear: clear_reg, bias: 1'b0};
                if (issue_last)
                begin
                    cls_next   = '0;
                    state_next = final_reg ? ST_BIAS : ST_IDLE;
                end
                else
                begin
                    cls_next = CLS_W'(cls_reg + CLS_W'(1));
                end
            end
            ST_BIAS:
            begin
                tok    = '{valid: 1'b1, cls: cls_reg, clear: 1'b0, bias: 1'b1};
                rd_pos = nf;
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cls_next = CLS_W'(cls_reg + CLS_W'(1));
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    oc_next    = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    oc_next = CLS_W'(oc_reg + CLS_W'(1));
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ec_reg    <= '0;
            pos_reg   <= '0;
            cls_reg   <= '0;
            oc_reg    <= '0;
            clear_reg <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ec_reg    <= ec_next;
            pos_reg   <= pos_next;
            cls_reg   <= cls_next;
            oc_reg    <= oc_next;
            clear_reg <= clear_next;
            final_reg <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        feat_reg <= feat_next;
    end

    assign wr_en   = accept && (command == CMD_LOAD)
                  && (32'(weight_class) < MAX_CLASSES)
                  && (32'(weight_position) <= MAX_FEATURES);
    assign wr_addr = ADDR_W'(ADDR_W'(weight_class) * ADDR_W'(ROW_LEN))
                   + ADDR_W'(weight_position);
    assign rd_addr = ADDR_W'(ADDR_W'(cls_reg) * ADDR_W'(ROW_LEN)) + ADDR_W'(rd_pos);

    lca_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (weight_value),
        .rd_en   (tok.valid),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lca_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_in     (tok),
        .weight     ($signed(rd_data)),
        .feature    (feat_reg),
        .rd_idx     (oc_reg),
        .rd_score   (acc_score),
        .best_score (mac_best_score),
        .best_label (mac_best_label),
        .busy       (mac_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cls_reg   <= oc_reg;
            out_score_reg <= acc_score;
            out_last_reg  <= emit_last;
            out_label_reg <= emit_last ? mac_best_label : '0;
            out_best_reg  <= emit_last ? mac_best_score : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign class_index = out_cls_reg;
    assign class_score = out_score_reg;
    assign last_of_run = out_last_reg;
    assign best_label  = out_label_reg;
    assign best_score  = out_best_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lca_checker.sv
// Port-level checker for the linear classifier argmax unit, bound to the top.
// Depends on lca_pkg and linear_classifier_argmax_unit.
`default_nettype none

module lca_checker
    import lca_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [CLS_W-1:0]          class_index,
    input wire logic signed [SCORE_W-1:0] class_score,
    input wire logic                      last_of_run,
    input wire logic signed [LABEL_W-1:0] best_label,
    input wire logic signed [SCORE_W-1:0] best_score
);

    // A result beat that is held back keeps out_valid, class index, score and last flag.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(class_index)
                                    && $stable(class_score) && $stable(last_of_run))
        else $error("result beat changed while stalled");

    a_non_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> (best_label == '0) && (best_score == '0))
        else $error("argmax fields set on a non-final result");

    // The best score bounds every score; the check covers the last class's score.
    a_best_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run |-> class_score <= best_score)
        else $error("last score exceeds best score");

    a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run && (best_label != LABEL_NONE)
            |-> (best_label >= 0) && (best_label <= $signed({1'b0, class_index})))
        else $error("best label outside the scored classes");

endmodule

bind linear_classifier_argmax_unit lca_checker u_lca_checker (.*);

`default_nettype wire
